FILE: sv/zbr_pkg.sv
`timescale 1ns / 1ps
package zbr_pkg;
   localparam int CW   = 14;   // row / column cursors, signed
   localparam int EW   = 18;   // pixel center offsets, signed
   localparam int CBW  = 17;   // edge coefficients, signed
   localparam int SNW  = 40;   // area and weight numerators, signed
   localparam int DW   = 36;   // magnitude of the area
   localparam int ACW  = 58;   // multiply-accumulate
   localparam int NUMW = 54;   // divider dividend
   localparam int QW   = 16;   // divider quotient
   localparam logic [15:0] DEPTH_MIN = 16'h8000;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_STEP  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_SETUP_A, ST_SETUP_B, ST_WALK,
      ST_N0A, ST_N0B, ST_N1A, ST_N1B, ST_COVER,
      ST_Z0, ST_Z1, ST_Z2, ST_DDIV, ST_DWAIT, ST_WDIV, ST_WWAIT
   } zbr_state_type;
endpackage

FILE: sv/scanline_triangle_zbuffer_raster.sv
`timescale 1ns / 1ps
// load: busy through the setup states SETUP_A and SETUP_B after the accepting edge.
// clear item and reset: busy while the sweep writes every entry of the depth store.
// step: pixels failing the coverage or depth test send it back to the walk; an emitted
// fragment or walk end closes the item; the result shows in the cycle busy drops.
// one shared multiplier and one 16-step restoring divider carry all arithmetic; one item at
// a time, results show for one cycle and the receiver cannot stall.
module scanline_triangle_zbuffer_raster #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic signed [15:0] req_v0_x,
   input  logic signed [15:0] req_v0_y,
   input  logic signed [15:0] req_v0_z,
   input  logic signed [15:0] req_v1_x,
   input  logic signed [15:0] req_v1_y,
   input  logic signed [15:0] req_v1_z,
   input  logic signed [15:0] req_v2_x,
   input  logic signed [15:0] req_v2_y,
   input  logic signed [15:0] req_v2_z,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [8:0]         csr_wdata,
   output logic               rsp_valid,
   output logic [7:0]         rsp_frag_x,
   output logic [7:0]         rsp_frag_y,
   output logic signed [15:0] rsp_frag_depth,
   output logic [15:0]        rsp_weight_a,
   output logic [15:0]        rsp_weight_b,
   output logic [15:0]        rsp_weight_c,
   output logic               rsp_done_res
);
   import zbr_pkg::*;

   localparam int SIZE = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADW  = $clog2(SIZE);

   zbr_state_type state_ff, state_in;

   logic signed [15:0]  v_ff [9];
   logic signed [15:0]  v_in [9];
   logic signed [CBW-1:0] c_ff [4];
   logic signed [CBW-1:0] c_in [4];
   logic signed [CW-1:0] row_ff, row_in, col_ff, col_in, end_ff, end_in, px_ff, px_in;
   logic                active_ff, active_in;
   logic signed [SNW-1:0] dsig_ff, dsig_in;
   logic signed [SNW-1:0] n_ff [3];
   logic signed [SNW-1:0] n_in [3];
   logic signed [ACW-1:0] acc_ff, acc_in;
   logic [1:0]          sel_ff, sel_in;
   logic [8:0]          scr_w_ff, scr_h_ff;
   logic [ADW-1:0]      clr_ff, clr_in;
   logic signed [15:0]  depth_ff, depth_in;
   logic [15:0]         w_ff [3];
   logic [15:0]         w_in [3];

   logic                rv_ff, rv_in, rd_ff, rd_in;
   logic [7:0]          rx_ff, rx_in, ry_ff, ry_in;
   logic [15:0]         rz_ff, rz_in, ra_ff, ra_in, rb_ff, rb_in, rc_ff, rc_in;

   logic signed [EW-1:0]  mul_a, ex, ey;
   logic signed [SNW-1:0] mul_b;
   logic signed [ACW-1:0] prod;
   logic signed [15:0]  xmin, xmax, ymin, ymax;
   logic signed [CW-1:0] effw, effh, span_s, span_e, last_row, first_row;
   logic signed [CW-1:0] xs_lo, xs_hi, ys_lo, ys_hi;
   logic signed [SNW-1:0] n2_raw, nn0, nn1, nn2, d_neg;
   logic [DW-1:0]       dabs;
   logic                div_start, div_done;
   logic [NUMW-1:0]     div_num;
   logic [QW-1:0]       div_quo;
   logic signed [15:0]  dp;
   logic                mem_we;
   logic [ADW-1:0]      mem_waddr, mem_raddr;
   logic [15:0]         mem_wdata, mem_rdata;
   logic signed [ACW-1:0] acc_sub;

   assign prod    = mul_a * mul_b;
   assign acc_sub = acc_ff - prod;

   // bounding box of the loaded triangle
   always_comb begin
      xmin = v_ff[0];
      xmax = v_ff[0];
      ymin = v_ff[1];
      ymax = v_ff[1];
      for (int k = 1; k < 3; k++) begin
         if (v_ff[3*k] < xmin) xmin = v_ff[3*k];
         if (v_ff[3*k] > xmax) xmax = v_ff[3*k];
         if (v_ff[3*k+1] < ymin) ymin = v_ff[3*k+1];
         if (v_ff[3*k+1] > ymax) ymax = v_ff[3*k+1];
      end
   end

   always_comb begin
      effw  = (int'(scr_w_ff) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(scr_w_ff);
      effh  = (int'(scr_h_ff) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(scr_h_ff);
      xs_lo = CW'(xmin >>> 4);
      xs_hi = CW'(xmax >>> 4);
      ys_lo = CW'(ymin >>> 4);
      ys_hi = CW'(ymax >>> 4);
      span_s = (xs_lo < 0) ? '0 : xs_lo;
      span_e = (xs_hi > effw - 1) ? effw - 1 : xs_hi;
      last_row = (ys_hi > effh - 1) ? effh - 1 : ys_hi;
      if (ys_lo < 0) begin
         first_row = '0;
      end else if (ys_lo > CW'(MAX_HEIGHT)) begin
         first_row = CW'(MAX_HEIGHT);
      end else begin
         first_row = ys_lo;
      end
   end

   // pixel center relative to vertex 2
   assign ex = (EW'(px_ff) <<< 4) + EW'(8) - EW'(v_ff[6]);
   assign ey = (EW'(row_ff) <<< 4) + EW'(8) - EW'(v_ff[7]);

   assign d_neg  = -dsig_ff;
   assign dabs   = dsig_ff[SNW-1] ? DW'(d_neg) : DW'(dsig_ff);
   assign n2_raw = dsig_ff - n_ff[0] - n_ff[1];
   assign nn0    = dsig_ff[SNW-1] ? -n_ff[0] : n_ff[0];
   assign nn1    = dsig_ff[SNW-1] ? -n_ff[1] : n_ff[1];
   assign nn2    = dsig_ff[SNW-1] ? -n2_raw : n2_raw;
   assign dp     = {~div_quo[QW-1], div_quo[QW-2:0]};

   assign mem_raddr = ADW'($unsigned(row_ff)) * ADW'(MAX_WIDTH) + ADW'($unsigned(px_ff));

   always_comb begin
      state_in  = state_ff;
      v_in      = v_ff;
      c_in      = c_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      end_in    = end_ff;
      px_in     = px_ff;
      active_in = active_ff;
      dsig_in   = dsig_ff;
      n_in      = n_ff;
      acc_in    = acc_ff;
      sel_in    = sel_ff;
      clr_in    = clr_ff;
      depth_in  = depth_ff;
      w_in      = w_ff;
      rv_in     = 1'b0;
      rd_in     = rd_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      rz_in     = rz_ff;
      ra_in     = ra_ff;
      rb_in     = rb_ff;
      rc_in     = rc_ff;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_num   = '0;
      mem_we    = 1'b0;
      mem_waddr = mem_raddr;
      mem_wdata = dp;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = DEPTH_MIN;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == ADW'(SIZE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               case (req_opcode)
                  OP_LOAD: begin
                     v_in[0] = req_v0_x; v_in[1] = req_v0_y; v_in[2] = req_v0_z;
                     v_in[3] = req_v1_x; v_in[4] = req_v1_y; v_in[5] = req_v1_z;
                     v_in[6] = req_v2_x; v_in[7] = req_v2_y; v_in[8] = req_v2_z;
                     c_in[0] = CBW'(req_v1_x) - CBW'(req_v2_x);
                     c_in[1] = CBW'(req_v1_y) - CBW'(req_v2_y);
                     c_in[2] = CBW'(req_v0_x) - CBW'(req_v2_x);
                     c_in[3] = CBW'(req_v0_y) - CBW'(req_v2_y);
                     state_in = ST_SETUP_A;
                  end
                  OP_STEP: state_in = ST_WALK;
                  OP_CLEAR: begin
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SETUP_A: begin
            row_in   = first_row;
            col_in   = span_s;
            end_in   = span_e;
            mul_a    = EW'(c_ff[3]);
            mul_b    = SNW'(c_ff[0]);
            acc_in   = prod;
            state_in = ST_SETUP_B;
         end
         ST_SETUP_B: begin
            mul_a     = EW'(c_ff[2]);
            mul_b     = SNW'(c_ff[1]);
            dsig_in   = SNW'(acc_sub);
            active_in = acc_sub != '0;
            state_in  = ST_IDLE;
         end
         ST_WALK: begin
            if (!active_ff || row_ff > last_row) begin
               active_in = 1'b0;
               rv_in = 1'b1;
               rd_in = 1'b1;
               rx_in = '0;
               ry_in = '0;
               rz_in = '0;
               ra_in = '0;
               rb_in = '0;
               rc_in = '0;
               state_in = ST_IDLE;
            end else if (col_ff > end_ff) begin
               row_in = row_ff + 1'b1;
               col_in = span_s;
               end_in = span_e;
            end else begin
               px_in    = col_ff;
               col_in   = col_ff + 1'b1;
               state_in = ST_N0A;
            end
         end
         ST_N0A: begin
            mul_a    = ey;
            mul_b    = SNW'(c_ff[0]);
            acc_in   = prod;
            state_in = ST_N0B;
         end
         ST_N0B: begin
            mul_a    = ex;
            mul_b    = SNW'(c_ff[1]);
            n_in[0]  = SNW'(acc_sub);
            state_in = ST_N1A;
         end
         ST_N1A: begin
            mul_a    = ex;
            mul_b    = SNW'(c_ff[3]);
            acc_in   = prod;
            state_in = ST_N1B;
         end
         ST_N1B: begin
            mul_a    = ey;
            mul_b    = SNW'(c_ff[2]);
            n_in[1]  = SNW'(acc_sub);
            state_in = ST_COVER;
         end
         ST_COVER: begin
            // weights taken with the sign of the area folded in
            n_in[0] = nn0;
            n_in[1] = nn1;
            n_in[2] = nn2;
            if (nn0[SNW-1] || nn1[SNW-1] || nn2[SNW-1]) begin
               state_in = ST_WALK;
            end else begin
               state_in = ST_Z0;
            end
         end
         ST_Z0: begin
            mul_a    = EW'(v_ff[2]);
            mul_b    = n_ff[0];
            acc_in   = prod;
            state_in = ST_Z1;
         end
         ST_Z1: begin
            mul_a    = EW'(v_ff[5]);
            mul_b    = n_ff[1];
            acc_in   = acc_ff + prod;
            state_in = ST_Z2;
         end
         ST_Z2: begin
            mul_a    = EW'(v_ff[8]);
            mul_b    = n_ff[2];
            acc_in   = acc_ff + prod;
            state_in = ST_DDIV;
         end
         ST_DDIV: begin
            // bias by 32768*|D| so the floor division becomes unsigned
            div_start = 1'b1;
            div_num   = NUMW'(acc_ff + $signed({1'b0, dabs, 15'b0}));
            state_in  = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_done) begin
               if (dp > $signed(mem_rdata)) begin
                  mem_we   = 1'b1;
                  depth_in = dp;
                  sel_in   = '0;
                  state_in = ST_WDIV;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WDIV: begin
            div_start = 1'b1;
            div_num   = NUMW'({n_ff[sel_ff][DW-1:0], 15'b0});
            state_in  = ST_WWAIT;
         end
         ST_WWAIT: begin
            if (div_done) begin
               w_in[sel_ff] = div_quo;
               if (sel_ff == 2'd2) begin
                  rv_in = 1'b1;
                  rd_in = 1'b0;
                  rx_in = px_ff[7:0];
                  ry_in = row_ff[7:0];
                  rz_in = depth_ff;
                  ra_in = w_ff[0];
                  rb_in = w_ff[1];
                  rc_in = div_quo;
                  state_in = ST_IDLE;
               end else begin
                  sel_in   = sel_ff + 1'b1;
                  state_in = ST_WDIV;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         end_ff    <= '0;
         active_ff <= 1'b0;
         rv_ff     <= 1'b0;
         scr_w_ff  <= 9'd256;
         scr_h_ff  <= 9'd256;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         end_ff    <= end_in;
         active_ff <= active_in;
         rv_ff     <= rv_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_WIDTH:  scr_w_ff <= csr_wdata;
               CSR_HEIGHT: scr_h_ff <= csr_wdata;
               default:    scr_w_ff <= scr_w_ff;
            endcase
         end
      end
      v_ff     <= v_in;
      c_ff     <= c_in;
      px_ff    <= px_in;
      dsig_ff  <= dsig_in;
      n_ff     <= n_in;
      acc_ff   <= acc_in;
      sel_ff   <= sel_in;
      depth_ff <= depth_in;
      w_ff     <= w_in;
      rd_ff    <= rd_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      rz_ff    <= rz_in;
      ra_ff    <= ra_in;
      rb_ff    <= rb_in;
      rc_ff    <= rc_in;
   end

   zbr_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .div_num   (div_num),
      .div_den   (dabs),
      .div_done  (div_done),
      .div_quo   (div_quo)
   );

   zbr_depth_mem #(
      .DEPTH (SIZE),
      .AW    (ADW)
   ) u_mem (
      .clock     (clock),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   assign busy           = state_ff != ST_IDLE;
   assign rsp_valid      = rv_ff;
   assign rsp_done_res   = rd_ff;
   assign rsp_frag_x     = rx_ff;
   assign rsp_frag_y     = ry_ff;
   assign rsp_frag_depth = rz_ff;
   assign rsp_weight_a   = ra_ff;
   assign rsp_weight_b   = rb_ff;
   assign rsp_weight_c   = rc_ff;
endmodule

FILE: sv/zbr_divider.sv
`timescale 1ns / 1ps
module zbr_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      div_start,
   input  logic [zbr_pkg::NUMW-1:0]  div_num,
   input  logic [zbr_pkg::DW-1:0]    div_den,
   output logic                      div_done,
   output logic [zbr_pkg::QW-1:0]    div_quo
);
   import zbr_pkg::*;

   localparam int CNTW = $clog2(QW + 1);

   logic [NUMW-1:0] rem_ff, rem_in, dsh_ff, dsh_in;
   logic [QW-1:0]   q_ff, q_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            run_ff, run_in, done_ff, done_in;
   logic            ge;

   // one quotient bit per cycle, divisor walks down from its top alignment
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      ge      = rem_ff >= dsh_ff;
      if (div_start) begin
         rem_in = div_num;
         dsh_in = NUMW'(div_den) << (QW - 1);
         q_in   = '0;
         cnt_in = CNTW'(QW);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         q_in   = {q_ff[QW-2:0], ge};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign div_done = done_ff;
   assign div_quo  = q_ff;
endmodule

FILE: sv/zbr_depth_mem.sv
`timescale 1ns / 1ps
module zbr_depth_mem #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  logic          clock,
   input  logic          mem_we,
   input  logic [AW-1:0] mem_waddr,
   input  logic [15:0]   mem_wdata,
   input  logic [AW-1:0] mem_raddr,
   output logic [15:0]   mem_rdata
);
   logic [15:0] mem_ff [DEPTH];
   logic [15:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem_ff[mem_raddr];
   end

   assign mem_rdata = rdata_ff;
endmodule

FILE: sv/zbr_checker.sv
`timescale 1ns / 1ps
module zbr_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_opcode,
   input logic        rsp_valid,
   input logic [7:0]  rsp_frag_x,
   input logic [7:0]  rsp_frag_y,
   input logic [15:0] rsp_frag_depth,
   input logic [15:0] rsp_weight_a,
   input logic [15:0] rsp_weight_b,
   input logic [15:0] rsp_weight_c,
   input logic        rsp_done_res
);
   import zbr_pkg::*;

   // a result only closes out an item that was in flight
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without item in flight");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results back to back");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_frag_x == 8'd0 && rsp_frag_y == 8'd0 &&
         rsp_frag_depth == 16'd0 && rsp_weight_a == 16'd0 &&
         rsp_weight_b == 16'd0 && rsp_weight_c == 16'd0)
      else $error("done item with nonzero fields");

   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |->
         (18'(rsp_weight_a) + 18'(rsp_weight_b) + 18'(rsp_weight_c)) <= 18'd32768)
      else $error("weights exceed one");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_opcode == OP_CLEAR |=> busy)
      else $error("clear item did not start a sweep");
endmodule

bind scanline_triangle_zbuffer_raster zbr_checker u_zbr_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_opcode     (req_opcode),
   .rsp_valid      (rsp_valid),
   .rsp_frag_x     (rsp_frag_x),
   .rsp_frag_y     (rsp_frag_y),
   .rsp_frag_depth (rsp_frag_depth),
   .rsp_weight_a   (rsp_weight_a),
   .rsp_weight_b   (rsp_weight_b),
   .rsp_weight_c   (rsp_weight_c),
   .rsp_done_res   (rsp_done_res)
);

FILE: tb/sv/zbr_frag_checker.sv
`timescale 1ns / 1ps
module zbr_frag_checker
   import zbr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic signed [15:0] req_v0_x,
   input  logic signed [15:0] req_v0_y,
   input  logic signed [15:0] req_v0_z,
   input  logic signed [15:0] req_v1_x,
   input  logic signed [15:0] req_v1_y,
   input  logic signed [15:0] req_v1_z,
   input  logic signed [15:0] req_v2_x,
   input  logic signed [15:0] req_v2_y,
   input  logic signed [15:0] req_v2_z,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [8:0]         csr_wdata,
   input  logic               rsp_valid,
   input  logic [7:0]         rsp_frag_x,
   input  logic [7:0]         rsp_frag_y,
   input  logic signed [15:0] rsp_frag_depth,
   input  logic [15:0]        rsp_weight_a,
   input  logic [15:0]        rsp_weight_b,
   input  logic [15:0]        rsp_weight_c,
   input  logic               rsp_done_res,
   output int                 fail_count,
   output int                 pending
);
   localparam int MW = 256;
   localparam int MH = 256;

   typedef struct packed {
      logic [7:0]  x;
      logic [7:0]  y;
      logic [15:0] depth;
      logic [15:0] wa;
      logic [15:0] wb;
      logic [15:0] wc;
      logic        done;
   } frag_type;

   frag_type frag_q[$];
   shortint zbuf[0:MW*MH-1];
   int      vreg[9];
   longint  coef[4];
   int      y_order[3];
   int      row_c, col_c, span_e;
   bit      walking;
   int      scr_w, scr_h;

   function automatic longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if (a % b != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic int eff_w();
      return (scr_w > MW) ? MW : scr_w;
   endfunction

   function automatic int eff_h();
      return (scr_h > MH) ? MH : scr_h;
   endfunction

   function automatic longint tri_area();
      return coef[3] * coef[0] - coef[2] * coef[1];
   endfunction

   // column range of the current row, from the x extent of the triangle
   function automatic void open_span();
      int     lo, hi;
      longint s, e;
      lo = vreg[0];
      hi = vreg[0];
      for (int k = 1; k < 3; k++) begin
         if (vreg[k*3] < lo) lo = vreg[k*3];
         if (vreg[k*3] > hi) hi = vreg[k*3];
      end
      s = floor_div(lo, 16);
      e = floor_div(hi, 16);
      if (s < 0) s = 0;
      if (e > eff_w() - 1) e = eff_w() - 1;
      col_c  = int'(s);
      span_e = int'(e);
   endfunction

   function automatic int bottom_row();
      longint e;
      e = floor_div(vreg[y_order[2]*3+1], 16);
      if (e > eff_h() - 1) e = eff_h() - 1;
      return int'(e);
   endfunction

   function automatic void load_triangle(int v[9]);
      int     a, b, c;
      longint first;
      vreg = v;
      coef[0] = vreg[3] - vreg[6];
      coef[1] = vreg[4] - vreg[7];
      coef[2] = vreg[0] - vreg[6];
      coef[3] = vreg[1] - vreg[7];
      a = vreg[1];
      b = vreg[4];
      c = vreg[7];
      if (a > b) begin
         if (a > c) begin
            y_order[2] = 0;
            if (b > c) begin y_order[1] = 1; y_order[0] = 2; end
            else begin y_order[1] = 2; y_order[0] = 1; end
         end else begin
            y_order[2] = 2; y_order[1] = 0; y_order[0] = 1;
         end
      end else begin
         if (b > c) begin
            y_order[2] = 1;
            if (a > c) begin y_order[1] = 0; y_order[0] = 2; end
            else begin y_order[1] = 2; y_order[0] = 0; end
         end else begin
            y_order[2] = 2; y_order[1] = 1; y_order[0] = 0;
         end
      end
      first = floor_div(vreg[y_order[0]*3+1], 16);
      if (first < 0) first = 0;
      if (first > MH) first = MH;
      row_c = int'(first);
      open_span();
      walking = (tri_area() != 0);
   endfunction

   // coverage and depth test of one pixel center; updates the store on a hit
   function automatic bit shade_pixel(int x, int y, output frag_type f);
      longint d, ex, ey, n0, n1, n2, num, dp;
      int     addr;
      f  = '0;
      d  = tri_area();
      ex = longint'(x) * 16 + 8 - vreg[6];
      ey = longint'(y) * 16 + 8 - vreg[7];
      n0 = ey * coef[0] - ex * coef[1];
      n1 = ex * coef[3] - ey * coef[2];
      if (d == 0) return 1'b0;
      n2 = d - n0 - n1;
      if (d < 0) begin
         d = -d; n0 = -n0; n1 = -n1; n2 = -n2;
      end
      if (n0 < 0 || n1 < 0 || n2 < 0) return 1'b0;
      num  = longint'(vreg[2]) * n0 + longint'(vreg[5]) * n1 + longint'(vreg[8]) * n2;
      dp   = floor_div(num, d);
      addr = (y * MW + x) % (MW * MH);
      if (dp <= zbuf[addr]) return 1'b0;
      zbuf[addr] = shortint'(dp);
      f.x     = x[7:0];
      f.y     = y[7:0];
      f.depth = dp[15:0];
      f.wa    = 16'((n0 * 32768) / d);
      f.wb    = 16'((n1 * 32768) / d);
      f.wc    = 16'((n2 * 32768) / d);
      return 1'b1;
   endfunction

   function automatic frag_type next_fragment();
      frag_type f;
      int    x;
      while (walking) begin
         if (row_c > bottom_row()) begin
            walking = 1'b0;
            break;
         end
         if (col_c > span_e) begin
            row_c++;
            open_span();
            continue;
         end
         x = col_c;
         col_c++;
         if (shade_pixel(x, row_c, f)) return f;
      end
      f      = '0;
      f.done = 1'b1;
      return f;
   endfunction

   function automatic void wipe_store();
      foreach (zbuf[i]) zbuf[i] = -16'sd32768;
   endfunction

   always @(posedge clock) begin
      frag_type got, want;
      int    v[9];
      if (reset) begin
         wipe_store();
         frag_q.delete();
         vreg    = '{default: 0};
         coef    = '{default: 0};
         y_order = '{default: 0};
         row_c   = 0;
         col_c   = 0;
         span_e  = 0;
         walking = 1'b0;
         scr_w   = 256;
         scr_h   = 256;
         fail_count = 0;
      end else begin
         if (rsp_valid) begin
            got = '{rsp_frag_x, rsp_frag_y, rsp_frag_depth, rsp_weight_a, rsp_weight_b,
                    rsp_weight_c, rsp_done_res};
            if (frag_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result x=%0d y=%0d depth=%0d done=%0b",
                           got.x, got.y, $signed(got.depth), got.done);
            end else begin
               want = frag_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"mismatch: expected x=%0d y=%0d depth=%0d w=%0d/%0d/%0d ",
                               "done=%0b, got x=%0d y=%0d depth=%0d w=%0d/%0d/%0d done=%0b"},
                              want.x, want.y, $signed(want.depth), want.wa, want.wb,
                              want.wc, want.done, got.x, got.y, $signed(got.depth),
                              got.wa, got.wb, got.wc, got.done);
               end
            end
         end
         if (csr_write_enable) begin
            if (csr_index == CSR_WIDTH) scr_w = csr_wdata;
            else scr_h = csr_wdata;
         end
         if (start && !busy) begin
            case (req_opcode)
               OP_LOAD: begin
                  v = '{req_v0_x, req_v0_y, req_v0_z, req_v1_x, req_v1_y, req_v1_z,
                        req_v2_x, req_v2_y, req_v2_z};
                  load_triangle(v);
               end
               OP_STEP:  frag_q.push_back(next_fragment());
               OP_CLEAR: wipe_store();
               default: ;
            endcase
         end
      end
      pending = frag_q.size();
   end
endmodule

FILE: tb/sv/tb_scanline_triangle_zbuffer_raster.sv
`timescale 1ns / 1ps
module tb_scanline_triangle_zbuffer_raster;
   import zbr_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 100000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_opcode = OP_STEP;
   logic signed [15:0] req_v0_x = '0, req_v0_y = '0, req_v0_z = '0;
   logic signed [15:0] req_v1_x = '0, req_v1_y = '0, req_v1_z = '0;
   logic signed [15:0] req_v2_x = '0, req_v2_y = '0, req_v2_z = '0;
   logic               csr_write_enable = 1'b0;
   logic               csr_index = CSR_WIDTH;
   logic [8:0]         csr_wdata = '0;
   logic               rsp_valid;
   logic [7:0]         rsp_frag_x, rsp_frag_y;
   logic signed [15:0] rsp_frag_depth;
   logic [15:0]        rsp_weight_a, rsp_weight_b, rsp_weight_c;
   logic               rsp_done_res;

   int                 fail_count, pending;
   int                 cycles = 0;
   int                 frags_seen = 0;
   bit                 last_done = 1'b0;
   int                 steps_sent = 0;
   int                 items_sent = 0;
   int                 idle_pct = 27;
   int                 cur_w = 256, cur_h = 256;
   logic signed [15:0] tri_v[9];

   always #5 clock = ~clock;

   scanline_triangle_zbuffer_raster DUT (.*);

   zbr_frag_checker u_checker (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (rsp_valid) begin
         frags_seen <= frags_seen + 1;
         last_done  <= rsp_done_res;
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send(input logic [1:0] op);
      while ($urandom_range(99) < idle_pct) @(posedge clock);
      req_opcode <= op;
      {req_v0_x, req_v0_y, req_v0_z} <= {tri_v[0], tri_v[1], tri_v[2]};
      {req_v1_x, req_v1_y, req_v1_z} <= {tri_v[3], tri_v[4], tri_v[5]};
      {req_v2_x, req_v2_y, req_v2_z} <= {tri_v[6], tri_v[7], tri_v[8]};
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 1'b0;
      if (op == OP_STEP) steps_sent++;
      if (op != OP_UNUSED) items_sent++;
      // the block is busy with the item during this cycle
      @(posedge clock);
   endtask

   task automatic step(output bit walk_done);
      send(OP_STEP);
      while (frags_seen != steps_sent) @(posedge clock);
      walk_done = last_done;
   endtask

   task automatic walk(input int max_steps);
      bit walk_done;
      for (int i = 0; i < max_steps; i++) begin
         step(walk_done);
         if (walk_done) break;
      end
   endtask

   task automatic settle();
      while (busy || frags_seen != steps_sent) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic set_screen(input int w, input int h);
      settle();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_WIDTH;
      csr_wdata        <= 9'(w);
      @(posedge clock);
      csr_index <= CSR_HEIGHT;
      csr_wdata <= 9'(h);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_w = (w > 256) ? 256 : w;
      cur_h = (h > 256) ? 256 : h;
   endtask

   task automatic set_tri(input int x0, y0, z0, x1, y1, z1, x2, y2, z2);
      tri_v = '{16'(x0), 16'(y0), 16'(z0), 16'(x1), 16'(y1), 16'(z1),
                16'(x2), 16'(y2), 16'(z2)};
   endtask

   // mostly small triangles near the screen, a few medium ones and a few
   // with arbitrary coordinates
   task automatic random_tri(output int max_steps);
      int r, spread, cx, cy;
      r = $urandom_range(99);
      max_steps = ($urandom_range(9) == 0) ? $urandom_range(1, 6) : 400;
      if (r < 3) begin
         foreach (tri_v[i]) tri_v[i] = 16'($urandom);
         max_steps = $urandom_range(1, 4);
      end else begin
         spread = (r < 8) ? 16 * 16 : 5 * 16;
         cx = $urandom_range(0, (cur_w + 6) * 16) - 48;
         cy = $urandom_range(0, (cur_h + 6) * 16) - 48;
         for (int k = 0; k < 3; k++) begin
            tri_v[k*3]   = 16'(cx + $urandom_range(0, 2 * spread) - spread);
            tri_v[k*3+1] = 16'(cy + $urandom_range(0, 2 * spread) - spread);
            tri_v[k*3+2] = 16'($urandom);
         end
      end
   endtask

   initial begin
      int screens[5][2];
      int budget, max_steps;
      screens = '{'{256, 256}, '{13, 7}, '{511, 40}, '{1, 1}, '{37, 300}};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // step with no walk, unused opcode, full walk, depth rejection of a redraw
      set_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
      walk(1);
      send(OP_UNUSED);
      set_tri(16, 8, 1000, 100, 20, -2000, 40, 90, 16383);
      send(OP_LOAD);
      walk(400);
      send(OP_LOAD);
      walk(400);
      set_tri(16, 8, 32767, 100, 20, 32767, 40, 90, 32767);
      send(OP_LOAD);
      walk(400);
      // zero area
      set_tri(0, 0, 5, 32, 32, 5, 64, 64, 5);
      send(OP_LOAD);
      walk(2);
      // extreme coordinates
      set_tri(-32768, -32768, -32768, 32767, -32768, 32767, -32768, 32767, 0);
      send(OP_LOAD);
      walk(3);
      send(OP_CLEAR);
      set_tri(20, 20, 100, 3000, 40, 100, 200, 3000, 100);
      send(OP_LOAD);
      walk(2);
      // height shrinks in the middle of a walk
      set_screen(256, 3);
      walk(400);
      set_screen(0, 0);
      set_tri(0, 0, 1, 64, 0, 1, 0, 64, 1);
      send(OP_LOAD);
      walk(2);
      set_screen(1, 1);
      set_tri(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767, -1);
      send(OP_LOAD);
      walk(400);

      for (int p = 0; p < 5; p++) begin
         set_screen(screens[p][0], screens[p][1]);
         if (p == 2 || p == 4) send(OP_CLEAR);
         budget = items_sent + 230;
         while (items_sent < budget) begin
            idle_pct = (items_sent < 400) ? 27 : (items_sent < 800) ? 55 : 0;
            case ($urandom_range(19))
               0: walk(1);
               1: send(OP_UNUSED);
               2: begin
                  random_tri(max_steps);
                  send(OP_LOAD);
               end
               default: begin
                  random_tri(max_steps);
                  send(OP_LOAD);
                  walk(max_steps);
               end
            endcase
         end
      end

      settle();
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
